// ----- rtl/lsb_pkg.sv -----
package lsb_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_X_PPM       = 2'd2,
    REG_Y_PPM       = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CORDIC,
    S_MULX,
    S_MULY,
    S_EVAL,
    S_WRITE,
    S_READ,
    S_FIN
  } state_t;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int XY_W         = 34;
  localparam int Z_W          = 26;
  localparam int PROD_W       = 51;
  localparam int V_W          = 53;
  localparam int POS_W        = 18;
  localparam int SIZE_W       = 13;
  localparam int WORD_BITS    = 64;
  localparam int BIT_W        = 6;

  localparam logic [15:0] GAIN_INV          = 16'd39797;
  localparam logic [15:0] START_ANGLE_RESET = 16'hC000;
  localparam logic [15:0] ANGLE_STEP_RESET  = 16'd182;
  localparam logic [15:0] PPM_RESET         = 16'd10923;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos;
  } pos_t;

  function automatic logic signed [Z_W-1:0] atan_turns(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      4'd0:    r = 26'sd2097152;
      4'd1:    r = 26'sd1238021;
      4'd2:    r = 26'sd654136;
      4'd3:    r = 26'sd332050;
      4'd4:    r = 26'sd166669;
      4'd5:    r = 26'sd83416;
      4'd6:    r = 26'sd41718;
      4'd7:    r = 26'sd20860;
      4'd8:    r = 26'sd10430;
      4'd9:    r = 26'sd5215;
      4'd10:   r = 26'sd2608;
      4'd11:   r = 26'sd1304;
      4'd12:   r = 26'sd652;
      4'd13:   r = 26'sd326;
      4'd14:   r = 26'sd163;
      4'd15:   r = 26'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // v = prod + size * 2^33, position = v / 2^34 truncated toward zero
  function automatic pos_t map_pos(input logic signed [PROD_W-1:0] prod,
                                   input logic [SIZE_W-1:0] size);
    logic signed [V_W-1:0] half;
    logic signed [V_W-1:0] v;
    pos_t r;
    half = V_W'($signed({1'b0, size})) <<< 33;
    v = V_W'(prod) + half;
    r.pos = '0;
    r.ok = 1'b0;
    if (v[V_W-1]) begin
      if ((&v[V_W-1:34]) && (v[33:0] != '0)) begin
        r.ok = 1'b1;
      end
    end else begin
      r.pos = v[POS_W+33:34];
      r.ok = (v[V_W-1:34] < {6'd0, size});
    end
    return r;
  endfunction

endpackage

// ----- rtl/lsb_if.sv -----
interface lsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] range;
  logic [7:0]  read_col;
  logic [7:0]  read_row;
  modport source(output valid, kind, range, read_col, read_row, input ready);
  modport sink(input valid, kind, range, read_col, read_row, output ready);
endinterface

interface lsb_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [7:0] pixel_col;
  logic [7:0] pixel_row;
  logic       pixel_value;
  modport source(output valid, hit, pixel_col, pixel_row, pixel_value, input ready);
  modport sink(input valid, hit, pixel_col, pixel_row, pixel_value, output ready);
endinterface

// ----- rtl/laser_scan_to_bitmap_top.sv -----
// Laser scan rasterizer.
// scan_in carries one word per item: kind 0 clears the bitmap and reloads the
// running angle, kind 1 is a range sample, kind 2 reads one stored pixel.
// result_out returns exactly one word per accepted item, in order.
// Config writes (cfg_we, cfg_index, cfg_wdata) are registered; the user must make
// them only while idle, which the block itself does not enforce. Work per item:
//   range sample, non-zero: 16 iterations of the shared CORDIC stage, two
//   multiplications into one product register, and one read-modify-write of
//   the bitmap word when the pixel lands in the image
//   zero range, kind 3: straight to the result; read: one bitmap word read
//   start: the one-word-per-cycle clear sweep of the bitmap memory
//   (ceil(IMG_WIDTH*IMG_HEIGHT/64) words)
// One item is in work at a time; the next is taken once the result sits in
// the output register. After reset the same clear sweep runs and scan_in
// ready stays low until it ends. When result_out stalls, the finished word
// is held and no new item is taken until the output register frees.
module laser_scan_to_bitmap_top import lsb_pkg::*; #(
  parameter int IMG_WIDTH  = 256,
  parameter int IMG_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  lsb_in_if.sink      scan_in,
  lsb_out_if.source   result_out
);

  localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
  localparam int NWORDS = (NPIX + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PAW    = $clog2(NPIX);
  localparam int IDX_W  = PAW + BIT_W;

  logic [15:0] start_angle;
  logic [15:0] angle_step;
  logic [15:0] x_pixels_per_meter;
  logic [15:0] y_pixels_per_meter;
  logic [15:0] angle;
  state_t      state;
  state_t      state_next;

  logic                     accept;
  logic                     rd_in_range;
  logic                     bm_clear;
  logic                     bm_busy;
  logic                     bm_rd_en;
  logic                     bm_wr_en;
  logic [WORD_BITS-1:0]     bm_rd_data;
  logic [WORD_BITS-1:0]     bm_wr_data;
  logic                     cor_start;
  logic                     cor_done;
  logic signed [XY_W-1:0]   cx;
  logic signed [XY_W-1:0]   sy;
  logic [SIZE_W-1:0]        idx_col;
  logic [SIZE_W-1:0]        idx_row;
  logic [2*SIZE_W-1:0]      idx_full;
  logic [IDX_W-1:0]         idx_ext;
  logic [WAW-1:0]           word_sel;
  logic [BIT_W-1:0]         bit_sel;
  logic [WAW-1:0]           word_q;
  logic [BIT_W-1:0]         bit_q;
  logic signed [PROD_W-1:0] prod;
  pos_t                     col_res;
  pos_t                     row_res;

  logic       out_valid;
  logic       out_hit;
  logic [7:0] out_col;
  logic [7:0] out_row;
  logic       out_value;
  logic       res_hit;
  logic [7:0] res_col;
  logic [7:0] res_row;
  logic       res_value;

  assign scan_in.ready = (state == S_IDLE) && !bm_busy;
  assign accept        = scan_in.valid && scan_in.ready;
  assign rd_in_range   = ({5'd0, scan_in.read_col} < SIZE_W'(IMG_WIDTH)) &&
                         ({5'd0, scan_in.read_row} < SIZE_W'(IMG_HEIGHT));
  assign row_res       = map_pos(prod, SIZE_W'(IMG_HEIGHT));

  assign idx_full = (2*SIZE_W)'(idx_row) * (2*SIZE_W)'(IMG_WIDTH) + (2*SIZE_W)'(idx_col);
  assign idx_ext  = IDX_W'(idx_full[PAW-1:0]);
  assign word_sel = idx_ext[WAW+BIT_W-1:BIT_W];
  assign bit_sel  = idx_ext[BIT_W-1:0];

  assign bm_wr_data = bm_rd_data | (WORD_BITS'(1) << bit_q);

  assign result_out.valid       = out_valid;
  assign result_out.hit         = out_hit;
  assign result_out.pixel_col   = out_col;
  assign result_out.pixel_row   = out_row;
  assign result_out.pixel_value = out_value;

  lsb_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .range (scan_in.range),
    .angle (angle),
    .done  (cor_done),
    .cx    (cx),
    .sy    (sy)
  );

  lsb_bitmap #(
    .NWORDS (NWORDS),
    .WAW    (WAW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .clear   (bm_clear),
    .busy    (bm_busy),
    .rd_en   (bm_rd_en),
    .rd_addr (word_sel),
    .rd_data (bm_rd_data),
    .wr_en   (bm_wr_en),
    .wr_addr (word_q),
    .wr_data (bm_wr_data)
  );

  always_comb begin
    state_next = state;
    bm_clear   = 1'b0;
    bm_rd_en   = 1'b0;
    bm_wr_en   = 1'b0;
    cor_start  = 1'b0;
    idx_col    = '0;
    idx_row    = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(scan_in.kind))
            KIND_START: begin
              bm_clear   = 1'b1;
              state_next = S_CLEAR;
            end
            KIND_RANGE: begin
              if (scan_in.range != '0) begin
                cor_start  = 1'b1;
                state_next = S_CORDIC;
              end else begin
                state_next = S_FIN;
              end
            end
            KIND_READ: begin
              if (rd_in_range) begin
                idx_col    = SIZE_W'(scan_in.read_col);
                idx_row    = SIZE_W'(scan_in.read_row);
                bm_rd_en   = 1'b1;
                state_next = S_READ;
              end else begin
                state_next = S_FIN;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_CLEAR: begin
        if (!bm_busy) begin
          state_next = S_FIN;
        end
      end
      S_CORDIC: begin
        if (cor_done) begin
          state_next = S_MULX;
        end
      end
      S_MULX: state_next = S_MULY;
      S_MULY: state_next = S_EVAL;
      S_EVAL: begin
        if (col_res.ok && row_res.ok) begin
          idx_col    = col_res.pos[SIZE_W-1:0];
          idx_row    = row_res.pos[SIZE_W-1:0];
          bm_rd_en   = 1'b1;
          state_next = S_WRITE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_WRITE: begin
        bm_wr_en   = 1'b1;
        state_next = S_FIN;
      end
      S_READ: state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || result_out.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      start_angle        <= START_ANGLE_RESET;
      angle_step         <= ANGLE_STEP_RESET;
      x_pixels_per_meter <= PPM_RESET;
      y_pixels_per_meter <= PPM_RESET;
      angle              <= START_ANGLE_RESET;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_START_ANGLE: start_angle        <= cfg_wdata;
          REG_ANGLE_STEP:  angle_step         <= cfg_wdata;
          REG_X_PPM:       x_pixels_per_meter <= cfg_wdata;
          REG_Y_PPM:       y_pixels_per_meter <= cfg_wdata;
          default:         ;
        endcase
      end
      if (accept && (kind_t'(scan_in.kind) == KIND_START)) begin
        angle <= start_angle;
      end else if (accept && (kind_t'(scan_in.kind) == KIND_RANGE)) begin
        angle <= angle + angle_step;
      end
      if (state == S_FIN && state_next == S_IDLE) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit   <= 1'b0;
      res_col   <= '0;
      res_row   <= '0;
      res_value <= 1'b0;
    end
    if (bm_rd_en) begin
      word_q <= word_sel;
      bit_q  <= bit_sel;
    end
    case (state)
      S_MULX: prod <= PROD_W'(cx) * PROD_W'($signed({1'b0, x_pixels_per_meter}));
      S_MULY: begin
        prod    <= PROD_W'(sy) * PROD_W'($signed({1'b0, y_pixels_per_meter}));
        col_res <= map_pos(prod, SIZE_W'(IMG_WIDTH));
      end
      S_EVAL: begin
        if (col_res.ok && row_res.ok) begin
          res_col <= col_res.pos[7:0];
          res_row <= row_res.pos[7:0];
        end
      end
      S_WRITE: res_hit   <= 1'b1;
      S_READ:  res_value <= bm_rd_data[bit_q];
      default: ;
    endcase
    if (state == S_FIN && state_next == S_IDLE) begin
      out_hit   <= res_hit;
      out_col   <= res_col;
      out_row   <= res_row;
      out_value <= res_value;
    end
  end

endmodule

// ----- rtl/lsb_cordic.sv -----
module lsb_cordic import lsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            range,
  input  logic [15:0]            angle,
  output logic                   done,
  output logic signed [XY_W-1:0] cx,
  output logic signed [XY_W-1:0] sy
);

  logic                   busy;
  logic [STEP_W-1:0]      step;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic [15:0]            sum;
  logic                   flip;
  logic [15:0]            ang_f;
  logic [31:0]            mag;
  logic signed [XY_W-1:0] x0;
  logic signed [Z_W-1:0]  z0;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  // fold angle into [-1/4, 1/4) turn
  assign sum   = angle + 16'h4000;
  assign flip  = sum[15];
  assign ang_f = flip ? (angle + 16'h8000) : angle;
  assign mag   = 32'(range) * 32'(GAIN_INV);
  assign x0    = flip ? -XY_W'(mag) : XY_W'(mag);
  assign z0    = Z_W'($signed({ang_f, 8'd0}));
  assign dx    = y >>> step;
  assign dy    = x >>> step;
  assign cx    = x;
  assign sy    = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= '0;
      z <= z0;
    end else if (busy) begin
      if (!z[Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_turns(step);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_turns(step);
      end
    end
  end

endmodule

// ----- rtl/lsb_bitmap.sv -----
module lsb_bitmap import lsb_pkg::*; #(
  parameter int NWORDS = 1024,
  parameter int WAW    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  output logic                 busy,
  input  logic                 rd_en,
  input  logic [WAW-1:0]       rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [WAW-1:0]       wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WAW-1:0]       clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (clear) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == WAW'(NWORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/lsb_scoreboard.sv -----
`timescale 1ns / 100ps
module lsb_scoreboard import lsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  lsb_in_if.sink      scan_mon,
  lsb_out_if.sink     res_mon,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic       hit;
    logic [7:0] col;
    logic [7:0] row;
    logic       value;
  } pixel_word_t;

  localparam int W = 256;
  localparam int H = 256;

  logic [15:0] start_ang, ang_step, x_ppm, y_ppm, ray_angle;
  logic        occupied [0:W*H-1];
  pixel_word_t expected_words [$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic bit scale_to_pixel(longint comp, longint ppm, longint size,
                                        output longint pos);
    longint v;
    v = comp * ppm + size * (64'sd1 <<< 33);
    pos = 0;
    if (v <= -(64'sd1 <<< 34)) return 0;
    pos = (v < 0) ? 0 : (v >>> 34);
    return pos < size;
  endfunction

  task automatic predict_word(input kind_t kind, input logic [15:0] rng,
                              input logic [7:0] rc, input logic [7:0] rr,
                              output pixel_word_t w);
    longint x, y, z, dx, dy, col, row;
    logic [15:0] a;
    int i;
    w = '0;
    case (kind)
      KIND_START: begin
        for (i = 0; i < W * H; i++) occupied[i] = 1'b0;
        ray_angle = start_ang;
      end
      KIND_RANGE: begin
        if (rng != 0) begin
          x = longint'(rng) * longint'(GAIN_INV);
          y = 0;
          a = ray_angle;
          if (((a + 16'h4000) & 16'h8000) != 0) begin
            a = a + 16'h8000;
            x = -x;
          end
          z = longint'($signed(a)) * 256;
          for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
              x -= dx; y += dy; z -= longint'(atan_turns(i[3:0]));
            end else begin
              x += dx; y -= dy; z += longint'(atan_turns(i[3:0]));
            end
          end
          if (scale_to_pixel(x, longint'(x_ppm), W, col) &&
              scale_to_pixel(y, longint'(y_ppm), H, row)) begin
            occupied[row * W + col] = 1'b1;
            w.hit = 1'b1;
            w.col = col[7:0];
            w.row = row[7:0];
          end
        end
        ray_angle = ray_angle + ang_step;
      end
      KIND_READ: w.value = occupied[int'(rr) * W + int'(rc)];
      default: ;
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_word_t e, w;
    if (rst) begin
      start_ang <= START_ANGLE_RESET;
      ang_step  <= ANGLE_STEP_RESET;
      x_ppm     <= PPM_RESET;
      y_ppm     <= PPM_RESET;
      ray_angle  = START_ANGLE_RESET;
      for (int i = 0; i < W * H; i++) occupied[i] = 1'b0;
      expected_words.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_START_ANGLE: start_ang <= cfg_wdata;
          REG_ANGLE_STEP:  ang_step  <= cfg_wdata;
          REG_X_PPM:       x_ppm     <= cfg_wdata;
          REG_Y_PPM:       y_ppm     <= cfg_wdata;
          default:         ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result word", $time);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (res_mon.hit !== e.hit) report("hit", res_mon.hit, e.hit);
          if (res_mon.pixel_col !== e.col) report("pixel_col", res_mon.pixel_col, e.col);
          if (res_mon.pixel_row !== e.row) report("pixel_row", res_mon.pixel_row, e.row);
          if (res_mon.pixel_value !== e.value)
            report("pixel_value", res_mon.pixel_value, e.value);
        end
      end
      if (scan_mon.valid && scan_mon.ready) begin
        predict_word(kind_t'(scan_mon.kind), scan_mon.range, scan_mon.read_col,
                     scan_mon.read_row, w);
        expected_words.push_back(w);
      end
      pending <= expected_words.size();
    end
  end

endmodule

// ----- tb/tb_laser_scan_to_bitmap_top.sv -----
`timescale 1ns / 100ps
module tb_laser_scan_to_bitmap_top import lsb_pkg::*;;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          errors, pending;
  logic [7:0]  last_col, last_row;

  lsb_in_if  scan_in();
  lsb_out_if result_out();

  laser_scan_to_bitmap_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .scan_in(scan_in.sink), .result_out(result_out.source)
  );

  lsb_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .scan_mon(scan_in.sink), .res_mon(result_out.sink),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_laser_scan_to_bitmap_top: errors");
    $finish;
  end

  always @(posedge clk)
    if (!rst && result_out.valid && result_out.ready && result_out.hit) begin
      last_col <= result_out.pixel_col;
      last_row <= result_out.pixel_row;
    end

  // receiver: random stalls, runs of no stall, one long hold-off
  initial begin
    int n, words, calm;
    words = 0;
    calm = 0;
    result_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (words == 300) n = 2500;
      else if (calm > 0) n = 0;
      else n = $urandom_range(0, 13);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 60);
      if (n > 0) begin
        result_out.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      result_out.ready = 1'b1;
      do @(posedge clk); while (!result_out.valid);
      words++;
      @(negedge clk);
    end
  end

  int gap_calm = 0;

  task automatic send_word(input kind_t kind, input logic [15:0] rng,
                           input logic [7:0] rc, input logic [7:0] rr);
    int n;
    if (gap_calm > 0) begin
      gap_calm--;
      n = 0;
    end else begin
      n = $urandom_range(0, 13);
      if ($urandom_range(0, 40) == 0) gap_calm = $urandom_range(20, 60);
    end
    if (n > 0) begin
      scan_in.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    scan_in.valid = 1'b1;
    scan_in.kind = kind;
    scan_in.range = rng;
    scan_in.read_col = rc;
    scan_in.read_row = rr;
    do @(posedge clk); while (!scan_in.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    scan_in.valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_word(KIND_START, 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 4) send_word(KIND_NONE, 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 12) send_word(KIND_RANGE, 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 70)
      send_word(KIND_RANGE, 16'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom));
    else if (r < 85) send_word(KIND_READ, 16'($urandom), last_col, last_row);
    else send_word(KIND_READ, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [15:0] sa [6] = '{16'hC000, 16'h8000, 16'h7FFF, 16'h0000, 16'h1234, 16'h4000};
    logic [15:0] st [6] = '{16'd182, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd1000};
    logic [15:0] xp [6] = '{16'd10923, 16'd0, 16'hFFFF, 16'd2560, 16'd300, 16'd10923};
    logic [15:0] yp [6] = '{16'd10923, 16'hFFFF, 16'd0, 16'd2560, 16'd40000, 16'd5000};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START_ANGLE;
    cfg_wdata = '0;
    scan_in.valid = 1'b0;
    scan_in.kind = KIND_START;
    scan_in.range = '0;
    scan_in.read_col = '0;
    scan_in.read_row = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // range before any start, then directed corners
    send_word(KIND_RANGE, 16'd1000, 8'd0, 8'd0);
    send_word(KIND_START, 16'hFFFF, 8'hFF, 8'hFF);
    send_word(KIND_RANGE, 16'd0, 8'hFF, 8'hFF);
    send_word(KIND_RANGE, 16'd1, 8'd0, 8'd0);
    send_word(KIND_RANGE, 16'd2000, 8'd0, 8'd0);
    send_word(KIND_READ, 16'd0, last_col, last_row);
    send_word(KIND_RANGE, 16'hFFFF, 8'd0, 8'd0);
    send_word(KIND_RANGE, 16'd3000, 8'd0, 8'd0);
    send_word(KIND_READ, 16'hFFFF, 8'd0, 8'd0);
    send_word(KIND_READ, 16'd0, 8'hFF, 8'hFF);
    send_word(KIND_READ, 16'd0, 8'd128, 8'd128);
    send_word(KIND_NONE, 16'hFFFF, 8'hFF, 8'hFF);
    send_word(KIND_RANGE, 16'd500, 8'd0, 8'd0);
    send_word(KIND_READ, 16'd0, last_col, last_row);
    send_word(KIND_START, 16'd0, 8'd0, 8'd0);
    send_word(KIND_READ, 16'd0, last_col, last_row);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_START_ANGLE, sa[p]);
      write_reg(REG_ANGLE_STEP, st[p]);
      write_reg(REG_X_PPM, xp[p]);
      write_reg(REG_Y_PPM, yp[p]);
      send_word(KIND_START, 16'($urandom), 8'($urandom), 8'($urandom));
      repeat (190) random_word();
      settle();
    end
    repeat (40) @(negedge clk);
    if (errors == 0) $display("tb_laser_scan_to_bitmap_top: clean");
    else $display("tb_laser_scan_to_bitmap_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lsb_pkg.sv
rtl/lsb_if.sv
rtl/lsb_cordic.sv
rtl/lsb_bitmap.sv
rtl/laser_scan_to_bitmap_top.sv
tb/lsb_scoreboard.sv
tb/tb_laser_scan_to_bitmap_top.sv
